@@ rtl/core/tsrp_pkg.sv @@
// Shared types, character codes and limits for the timestamped record parser.
`timescale 1ns / 1ps
`default_nettype none

package tsrp_pkg;

    localparam int LINE_COUNT_BITS = 24;
    localparam int S_DATA_W        = 8;
    localparam int M_DATA_W        = 96;

    localparam logic [23:0] LINE_SHOWN_MAX = 24'((64'(1) << LINE_COUNT_BITS) - 64'(1));

    localparam logic [7:0] CHR_NL    = 8'h0A;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_SEMI  = 8'h3B;

    localparam logic [2:0] FLD_YEAR   = 3'd0;
    localparam logic [2:0] FLD_MONTH  = 3'd1;
    localparam logic [2:0] FLD_DAY    = 3'd2;
    localparam logic [2:0] FLD_HOUR   = 3'd3;
    localparam logic [2:0] FLD_MINUTE = 3'd4;
    localparam logic [2:0] FLD_TEMP   = 3'd5;
    localparam logic [2:0] POS_MAX    = 3'd7;

    localparam logic [2:0] YEAR_DIGITS_LAST  = 3'd3;
    localparam logic [2:0] SHORT_DIGITS_LAST = 3'd1;

    localparam logic [7:0]  MONTH_MAX      = 8'd12;
    localparam logic [7:0]  DAY_MAX_LONG   = 8'd31;
    localparam logic [7:0]  DAY_MAX_SHORT  = 8'd30;
    localparam logic [7:0]  DAY_MAX_FEB    = 8'd29;
    localparam logic [7:0]  HOUR_MAX       = 8'd24;
    localparam logic [7:0]  MINUTE_MAX     = 8'd60;
    localparam logic signed [15:0] TEMP_MAX = 16'sd99;
    localparam logic signed [15:0] TEMP_MIN = -16'sd99;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_YEAR   = 3'd1,
        ERR_MONTH  = 3'd2,
        ERR_DAY    = 3'd3,
        ERR_HOUR   = 3'd4,
        ERR_MINUTE = 3'd5,
        ERR_TEMP   = 3'd6,
        ERR_EXTRA  = 3'd7
    } t_err_code;

    typedef struct packed {
        logic        record_ok;
        logic [15:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [15:0] temp;
        t_err_code   err;
        logic [23:0] line;
    } t_record;

    function automatic logic [15:0] year_weight(input logic [2:0] pos);
        case (pos)
            3'd0:    year_weight = 16'd1000;
            3'd1:    year_weight = 16'd100;
            3'd2:    year_weight = 16'd10;
            default: year_weight = 16'd1;
        endcase
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/tsrp_parser.sv @@
// Per-line parse state, field accumulators and line-end checks.
`timescale 1ns / 1ps
`default_nettype none

module tsrp_parser
    import tsrp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_char,
    output logic            o_emit,
    output t_record         o_rec
);

    logic [2:0]                 r_field_pos, n_field_pos;
    logic [2:0]                 r_digit_pos, n_digit_pos;
    logic [15:0]                r_year, n_year;
    logic [7:0]                 r_month, n_month;
    logic [7:0]                 r_day, n_day;
    logic [7:0]                 r_hour, n_hour;
    logic [7:0]                 r_minute, n_minute;
    logic [15:0]                r_temp, n_temp;
    logic                       r_neg, n_neg;
    logic                       r_line_err, n_line_err;
    t_err_code                  r_last_err, n_last_err;
    logic [LINE_COUNT_BITS-1:0] r_line_cnt, n_line_cnt;

    logic [7:0]  c;
    logic [7:0]  d;
    logic        is_digit;
    logic        first;
    logic [15:0] tv;
    logic        e_flag;
    t_err_code   e_code;
    logic [7:0]  day_lim;
    logic        day_chk;
    logic [31:0] cnt_ext;

    function automatic logic [7:0] dec8(input logic [7:0] acc, input logic [3:0] dd,
                                        input logic is_first);
        logic [7:0] ext;
        ext = {4'd0, dd};
        if (is_first) begin
            dec8 = ext;
        end else begin
            dec8 = (acc << 3) + (acc << 1) + ext;
        end
    endfunction

    assign c        = (i_char == CHR_SPACE) ? CHR_ZERO : i_char;
    assign d        = c - CHR_ZERO;
    assign is_digit = (c >= CHR_ZERO) && (c <= CHR_NINE);
    assign first    = (r_digit_pos == 3'd0);
    assign o_emit   = (c == CHR_NL);

    always_comb begin
        n_field_pos = r_field_pos;
        n_digit_pos = r_digit_pos;
        n_year      = r_year;
        n_month     = r_month;
        n_day       = r_day;
        n_hour      = r_hour;
        n_minute    = r_minute;
        n_temp      = r_temp;
        n_neg       = r_neg;
        n_line_err  = r_line_err;
        n_last_err  = r_last_err;
        n_line_cnt  = r_line_cnt;
        tv          = {8'd0, c} - {8'd0, CHR_ZERO};
        if (i_step) begin
            if (c == CHR_NL) begin
                n_field_pos = FLD_YEAR;
                n_digit_pos = 3'd0;
                n_year      = '0;
                n_month     = '0;
                n_day       = '0;
                n_hour      = '0;
                n_minute    = '0;
                n_temp      = '0;
                n_neg       = 1'b0;
                n_line_err  = 1'b0;
                n_last_err  = ERR_NONE;
                n_line_cnt  = r_line_cnt + 1'b1;
            end else if (c == CHR_SEMI) begin
                n_digit_pos = 3'd0;
                if (r_field_pos != POS_MAX) begin
                    n_field_pos = r_field_pos + 3'd1;
                end
            end else begin
                if (is_digit) begin
                    case (r_field_pos)
                        FLD_YEAR: begin
                            if (r_digit_pos > YEAR_DIGITS_LAST) begin
                                n_line_err = 1'b1;
                                n_last_err = ERR_YEAR;
                            end
                            n_year = r_year + 16'({12'd0, d[3:0]} * year_weight(r_digit_pos));
                        end
                        FLD_MONTH: begin
                            if (r_digit_pos > SHORT_DIGITS_LAST) begin
                                n_line_err = 1'b1;
                                n_last_err = ERR_MONTH;
                            end
                            n_month = dec8(r_month, d[3:0], first);
                        end
                        FLD_DAY: begin
                            if (r_digit_pos > SHORT_DIGITS_LAST) begin
                                n_line_err = 1'b1;
                                n_last_err = ERR_DAY;
                            end
                            n_day = dec8(r_day, d[3:0], first);
                        end
                        FLD_HOUR: begin
                            if (r_digit_pos > SHORT_DIGITS_LAST) begin
                                n_line_err = 1'b1;
                                n_last_err = ERR_HOUR;
                            end
                            n_hour = dec8(r_hour, d[3:0], first);
                        end
                        FLD_MINUTE: begin
                            if (r_digit_pos > SHORT_DIGITS_LAST) begin
                                n_line_err = 1'b1;
                                n_last_err = ERR_MINUTE;
                            end
                            n_minute = dec8(r_minute, d[3:0], first);
                        end
                        default: begin
                        end
                    endcase
                end else if (r_field_pos < FLD_TEMP) begin
                    n_line_err = 1'b1;
                    n_last_err = t_err_code'(r_field_pos + 3'd1);
                end
                // Every temperature byte except the sign is accumulated as a digit.
                if (r_field_pos == FLD_TEMP) begin
                    if (c == CHR_MINUS) begin
                        n_neg = 1'b1;
                    end else begin
                        if (r_neg) begin
                            tv = 16'd0 - tv;
                        end
                        if (!first) begin
                            tv = tv + (r_temp << 3) + (r_temp << 1);
                        end
                        n_temp = tv;
                    end
                end
                if (r_digit_pos != POS_MAX) begin
                    n_digit_pos = r_digit_pos + 3'd1;
                end
            end
        end
    end

    // Line-end checks; a later check overrides an earlier one.
    always_comb begin
        e_flag  = 1'b0;
        e_code  = ERR_NONE;
        day_chk = 1'b1;
        case (r_month) inside
            8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: day_lim = DAY_MAX_LONG;
            8'd4, 8'd6, 8'd9, 8'd11:                    day_lim = DAY_MAX_SHORT;
            8'd2:                                       day_lim = DAY_MAX_FEB;
            default: begin
                day_lim = DAY_MAX_LONG;
                day_chk = 1'b0;
            end
        endcase
        if ((r_month > MONTH_MAX) || (r_month == 8'd0)) begin
            e_flag = 1'b1;
            e_code = ERR_MONTH;
        end
        if (day_chk && ((r_day > day_lim) || (r_day == 8'd0))) begin
            e_flag = 1'b1;
            e_code = ERR_DAY;
        end
        if (r_hour > HOUR_MAX) begin
            e_flag = 1'b1;
            e_code = ERR_HOUR;
        end
        if (r_minute > MINUTE_MAX) begin
            e_flag = 1'b1;
            e_code = ERR_MINUTE;
        end
        if (($signed(r_temp) > TEMP_MAX) || ($signed(r_temp) < TEMP_MIN)) begin
            e_flag = 1'b1;
            e_code = ERR_TEMP;
        end
        if (r_field_pos > FLD_TEMP) begin
            e_flag = 1'b1;
            e_code = ERR_EXTRA;
        end
    end

    assign cnt_ext = 32'(r_line_cnt);

    always_comb begin
        o_rec.record_ok = !(r_line_err || e_flag);
        o_rec.year      = r_year;
        o_rec.month     = r_month;
        o_rec.day       = r_day;
        o_rec.hour      = r_hour;
        o_rec.minute    = r_minute;
        o_rec.temp      = r_temp;
        o_rec.err       = e_flag ? e_code : (r_line_err ? r_last_err : ERR_NONE);
        o_rec.line      = cnt_ext[23:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_pos <= FLD_YEAR;
            r_digit_pos <= 3'd0;
            r_year      <= '0;
            r_month     <= '0;
            r_day       <= '0;
            r_hour      <= '0;
            r_minute    <= '0;
            r_temp      <= '0;
            r_neg       <= 1'b0;
            r_line_err  <= 1'b0;
            r_last_err  <= ERR_NONE;
            r_line_cnt  <= '0;
        end else begin
            r_field_pos <= n_field_pos;
            r_digit_pos <= n_digit_pos;
            r_year      <= n_year;
            r_month     <= n_month;
            r_day       <= n_day;
            r_hour      <= n_hour;
            r_minute    <= n_minute;
            r_temp      <= n_temp;
            r_neg       <= n_neg;
            r_line_err  <= n_line_err;
            r_last_err  <= n_last_err;
            r_line_cnt  <= n_line_cnt;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/timestamped_record_parser_top.sv @@
// A newline byte is registered at the input, then its record word at the output.
// Throughput: one text byte per cycle; the input register feeds the parser and the
// output register holds a record while the next bytes keep flowing in.
// Only a newline that meets a full, stalled output register holds the input side.
// Reset is synchronous and active low; it clears the line state and line counter.
`timescale 1ns / 1ps
`default_nettype none

module timestamped_record_parser_top
    import tsrp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    input  wire logic [S_DATA_W-1:0] i_s_tdata,  // [7:0] char_in
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    // [15:0] year_value, [23:16] month_value, [31:24] day_value, [39:32] hour_value,
    // [47:40] minute_value, [63:48] temperature_value, [66:64] error_field,
    // [90:67] line_number, [95:91] zero
    output logic [M_DATA_W-1:0]      o_m_tdata,
    output logic                     o_m_tuser   // [0] record_ok
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_out_valid;
    t_record    r_out_rec;

    logic    emit;
    logic    out_free;
    logic    adv;
    t_record rec;

    tsrp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_char  (r_in_char),
        .o_emit  (emit),
        .o_rec   (rec)
    );

    assign out_free   = !r_out_valid || i_m_tready;
    assign adv        = r_in_valid && (!emit || out_free);
    assign o_s_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_char <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_out_rec <= rec;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_rec.record_ok;
    assign o_m_tdata  = {5'd0, r_out_rec.line, r_out_rec.err, r_out_rec.temp,
                         r_out_rec.minute, r_out_rec.hour, r_out_rec.day,
                         r_out_rec.month, r_out_rec.year};

endmodule

`default_nettype wire

@@ rtl/core/tsrp_checker.sv @@
// Port-level assertions for the record parser and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tsrp_checker
    import tsrp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                o_m_tvalid,
    input  wire logic                i_m_tready,
    input  wire logic [M_DATA_W-1:0] o_m_tdata,
    input  wire logic                o_m_tuser
);

    logic        r_seen;
    logic [23:0] r_last_line;
    logic        out_acc;
    logic [23:0] line_now;
    logic [23:0] line_next;

    assign out_acc   = o_m_tvalid && i_m_tready;
    assign line_now  = o_m_tdata[90:67];
    assign line_next = (r_last_line == LINE_SHOWN_MAX) ? 24'd0 : r_last_line + 24'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_last_line <= '0;
        end else if (out_acc) begin
            r_seen      <= 1'b1;
            r_last_line <= line_now;
        end
    end

    // A record is good exactly when it carries no error code.
    a_ok_matches_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == (o_m_tdata[66:64] == ERR_NONE)))
        else $error("record_ok disagrees with error_field");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled output word changed");

    a_first_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !r_seen) |-> (line_now == 24'd0))
        else $error("first record after reset is not line zero");

    a_line_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_seen) |-> (line_now == line_next))
        else $error("line number skipped or repeated");

endmodule

bind timestamped_record_parser_top tsrp_checker u_tsrp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking stream testbench for the timestamped record parser top level.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import tsrp_pkg::*;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata  = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;
    logic                o_m_tuser;

    timestamped_record_parser_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #6 i_clk = ~i_clk;

    logic [7:0] text_bytes[$];
    t_record    pending_records[$];
    int         total_chars    = 0;
    int         accepted_chars = 0;
    int         mismatches     = 0;
    int         phase          = 0;
    logic       hold_rx        = 1'b0;

    logic [2:0]  fld_pos  = '0;
    logic [2:0]  dig_pos  = '0;
    logic [15:0] yr       = '0;
    logic [7:0]  mon      = '0;
    logic [7:0]  dy       = '0;
    logic [7:0]  hr       = '0;
    logic [7:0]  mn       = '0;
    logic [15:0] tmp      = '0;
    logic        neg      = 1'b0;
    logic        bad      = 1'b0;
    t_err_code   last_err = ERR_NONE;
    logic [23:0] line_cnt = '0;

    function automatic void mark_error(input t_err_code code);
        bad      = 1'b1;
        last_err = code;
    endfunction

    function automatic logic [7:0] next_decimal(input logic [7:0] acc, input logic [7:0] d);
        return (dig_pos == 3'd0) ? d : acc * 8'd10 + d;
    endfunction

    task automatic parse_char(input logic [7:0] raw);
        logic [7:0]  ch;
        logic [7:0]  d;
        logic [15:0] w;
        logic [15:0] tv;
        t_record     rec;
        ch = (raw == CHR_SPACE) ? CHR_ZERO : raw;
        d  = ch - CHR_ZERO;
        if (ch == CHR_NL) begin
            if (mon < 8'd1 || mon > MONTH_MAX)
                mark_error(ERR_MONTH);
            case (mon)
                8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: begin
                    if (dy < 8'd1 || dy > DAY_MAX_LONG) mark_error(ERR_DAY);
                end
                8'd4, 8'd6, 8'd9, 8'd11: begin
                    if (dy < 8'd1 || dy > DAY_MAX_SHORT) mark_error(ERR_DAY);
                end
                8'd2: begin
                    if (dy < 8'd1 || dy > DAY_MAX_FEB) mark_error(ERR_DAY);
                end
                default: ;
            endcase
            if (hr > HOUR_MAX)
                mark_error(ERR_HOUR);
            if (mn > MINUTE_MAX)
                mark_error(ERR_MINUTE);
            if ($signed(tmp) > TEMP_MAX || $signed(tmp) < TEMP_MIN)
                mark_error(ERR_TEMP);
            if (fld_pos > FLD_TEMP)
                mark_error(ERR_EXTRA);
            rec.record_ok = !bad;
            rec.year      = yr;
            rec.month     = mon;
            rec.day       = dy;
            rec.hour      = hr;
            rec.minute    = mn;
            rec.temp      = tmp;
            rec.err       = bad ? last_err : ERR_NONE;
            rec.line      = line_cnt;
            pending_records.push_back(rec);
            line_cnt = line_cnt + 24'd1;
            fld_pos  = '0;
            dig_pos  = '0;
            yr       = '0;
            mon      = '0;
            dy       = '0;
            hr       = '0;
            mn       = '0;
            tmp      = '0;
            neg      = 1'b0;
            bad      = 1'b0;
            last_err = ERR_NONE;
        end else if (ch == CHR_SEMI) begin
            dig_pos = '0;
            if (fld_pos < POS_MAX)
                fld_pos = fld_pos + 3'd1;
        end else begin
            if (ch >= CHR_ZERO && ch <= CHR_NINE) begin
                case (fld_pos)
                    FLD_YEAR: begin
                        if (dig_pos > 3'd3) mark_error(ERR_YEAR);
                        case (dig_pos)
                            3'd0:    w = 16'd1000;
                            3'd1:    w = 16'd100;
                            3'd2:    w = 16'd10;
                            default: w = 16'd1;
                        endcase
                        yr = yr + 16'(d) * w;
                    end
                    FLD_MONTH: begin
                        if (dig_pos > 3'd1) mark_error(ERR_MONTH);
                        mon = next_decimal(mon, d);
                    end
                    FLD_DAY: begin
                        if (dig_pos > 3'd1) mark_error(ERR_DAY);
                        dy = next_decimal(dy, d);
                    end
                    FLD_HOUR: begin
                        if (dig_pos > 3'd1) mark_error(ERR_HOUR);
                        hr = next_decimal(hr, d);
                    end
                    FLD_MINUTE: begin
                        if (dig_pos > 3'd1) mark_error(ERR_MINUTE);
                        mn = next_decimal(mn, d);
                    end
                    default: ;
                endcase
            end else if (fld_pos < FLD_TEMP) begin
                mark_error(t_err_code'(fld_pos + 3'd1));
            end
            if (fld_pos == FLD_TEMP) begin
                if (ch == CHR_MINUS) begin
                    neg = 1'b1;
                end else begin
                    tv = 16'(ch) - 16'd48;
                    if (neg)
                        tv = -tv;
                    if (dig_pos != 3'd0)
                        tv = tv + tmp * 16'd10;
                    tmp = tv;
                end
            end
            if (dig_pos < POS_MAX)
                dig_pos = dig_pos + 3'd1;
        end
    endtask

    function automatic void compare_field(input string name, input logic [23:0] want,
                                          input logic [23:0] got, input logic [23:0] line);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch in %s of line %0d: expected %0h, got %0h",
                         name, line, want, got);
        end
    endfunction

    task automatic check_record();
        t_record want;
        if (pending_records.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Record word with no pending line: tdata %h tuser %b",
                         o_m_tdata, o_m_tuser);
        end else begin
            want = pending_records.pop_front();
            compare_field("record_ok", want.record_ok, o_m_tuser, want.line);
            compare_field("year", want.year, o_m_tdata[15:0], want.line);
            compare_field("month", want.month, o_m_tdata[23:16], want.line);
            compare_field("day", want.day, o_m_tdata[31:24], want.line);
            compare_field("hour", want.hour, o_m_tdata[39:32], want.line);
            compare_field("minute", want.minute, o_m_tdata[47:40], want.line);
            compare_field("temperature", want.temp, o_m_tdata[63:48], want.line);
            compare_field("error code", want.err, o_m_tdata[66:64], want.line);
            compare_field("line number", want.line, o_m_tdata[90:67], want.line);
            compare_field("padding", 24'd0, o_m_tdata[95:91], want.line);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                parse_char(i_s_tdata);
                accepted_chars++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (text_bytes.size() != 0 &&
                    $urandom_range(0, 99) >= ((phase == 0) ? 29 : (phase == 1) ? 82 : 0)) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= text_bytes.pop_front();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready)
                check_record();
            i_m_tready <= !hold_rx &&
                ($urandom_range(0, 99) >= ((phase == 0) ? 82 : (phase == 1) ? 29 : 0));
        end
    end

    // Long receiver stall at the start of the full-rate phase so that the
    // output register fills and a newline backs up into the input side.
    initial begin
        wait (phase == 2);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    initial begin
        #2000000;
        $display("FAIL timestamped_record_parser_top");
        $finish;
    end

    task automatic queue_char(input logic [7:0] b);
        text_bytes.push_back(b);
        total_chars++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_char(s[i]);
    endtask

    function automatic string padded(input int unsigned v, input int w);
        string s;
        s = $sformatf("%0d", v);
        while (s.len() < w) begin
            if ($urandom_range(0, 9) == 0)
                s = {" ", s};
            else
                s = {"0", s};
        end
        return s;
    endfunction

    function automatic int pick_width(input int w);
        return ($urandom_range(0, 9) < 7) ? w : $urandom_range(1, w + 1);
    endfunction

    function automatic int unsigned field_value(input int unsigned hi);
        return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 999) : $urandom_range(0, hi);
    endfunction

    task automatic queue_random_line(inout int added);
        string       s;
        int          n;
        int          bad_at;
        int unsigned mag;
        s = "";
        if ($urandom_range(0, 99) < 75) begin
            s = {padded($urandom_range(0, 9999), pick_width(4)), ";",
                 padded(field_value(13), pick_width(2)), ";",
                 padded(field_value(32), pick_width(2)), ";",
                 padded(field_value(25), pick_width(2)), ";",
                 padded(field_value(61), pick_width(2)), ";"};
            mag = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 99999)
                                               : $urandom_range(0, 120);
            if ($urandom_range(0, 9) < 4)
                s = {s, "-"};
            s = {s, padded(mag, $urandom_range(1, 3))};
            if ($urandom_range(0, 9) == 0)
                s = {s, ";", padded($urandom_range(0, 99), 1)};
            bad_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, s.len() - 1) : -1;
            for (int i = 0; i < s.len(); i++)
                queue_char((i == bad_at) ? 8'($urandom_range(0, 255)) : s[i]);
            added += s.len() + 1;
        end else begin
            n = $urandom_range(0, 30);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 9))
                    0, 1:    queue_char(CHR_SEMI);
                    2, 3, 4: queue_char(CHR_ZERO + 8'($urandom_range(0, 9)));
                    default: queue_char(8'($urandom_range(0, 255)));
                endcase
            end
            added += n + 1;
        end
        queue_char(CHR_NL);
    endtask

    initial begin
        int added;
        queue_text("2024;2;29;0;0;-99\n");
        queue_text("   1;12;31;24;60;99\n");
        queue_text("12345;13;32;25;61;100;7\n");
        queue_text("1;1;0;1;1;-100\n");
        queue_text("2000;4;31;123;5;7a\n");
        queue_text("1;2;30;1;1;1\n");
        queue_text("20x0;ab;\n");
        queue_text("\n");
        queue_text("9;11;30;; ;--5;;;;;;;\n");
        queue_text("1;");
        queue_char(8'hFF);
        queue_char(CHR_SEMI);
        queue_char(8'h00);
        queue_char(CHR_NL);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < 3; p++) begin
            if (p != 0) begin
                while (text_bytes.size() != 0)
                    @(posedge i_clk);
                phase <= p;
            end
            added = 0;
            while (added < 350)
                queue_random_line(added);
        end

        while (accepted_chars < total_chars)
            @(posedge i_clk);
        while (pending_records.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS timestamped_record_parser_top");
        else
            $display("FAIL timestamped_record_parser_top");
        $finish;
    end

endmodule

`default_nettype wire
